/* sv/bls_pkg.sv */
// ---------------------------------------------------------------------------
// bls_pkg: shared types and constants for the line span generator
// Screen limits, field widths and the line descriptor passed from the
// command front end through the descriptor queue to the span walker.
// ---------------------------------------------------------------------------
package bls_pkg;

  // Screen limits; coordinates at or beyond them saturate to the edge
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;

  // Field widths
  localparam int X_W     = 7;
  localparam int Y_W     = 6;
  localparam int COORD_W = (X_W > Y_W) ? X_W : Y_W;
  localparam int LEN_W   = 8;
  localparam int COLOR_W = 8;
  // Error term: -(2^COORD_W-1) .. 2^COORD_W-1, two's complement
  localparam int ERR_W   = COORD_W + 1;
  localparam int CMP_W   = 9;

  // Descriptor queue between front end and walker
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified line, ordered so the major coordinate increases
  typedef struct packed {
    logic [COORD_W-1:0] major_start;
    logic [COORD_W-1:0] major_end;
    logic [COORD_W-1:0] minor_start;
    logic [COORD_W-1:0] major_delta;
    logic [COORD_W-1:0] minor_delta;
    logic               minor_step_down;
    logic               steep;
    logic [COLOR_W-1:0] color;
  } line_desc_t;

  // Clamp a column to the screen width
  function automatic logic [X_W-1:0] sat_col(input logic [X_W-1:0] v);
    logic [X_W-1:0] r;
    r = v;
    if (CMP_W'(v) >= CMP_W'(SCREEN_WIDTH)) r = X_W'(SCREEN_WIDTH - 1);
    return r;
  endfunction

  // Clamp a row to the screen height
  function automatic logic [Y_W-1:0] sat_row(input logic [Y_W-1:0] v);
    logic [Y_W-1:0] r;
    r = v;
    if (CMP_W'(v) >= CMP_W'(SCREEN_HEIGHT)) r = Y_W'(SCREEN_HEIGHT - 1);
    return r;
  endfunction

endpackage

/* sv/bls_cmd_if.sv */
// ---------------------------------------------------------------------------
// bls_cmd_if: line command channel
// Valid/ready channel carrying two endpoints and a pen color.
// ---------------------------------------------------------------------------
interface bls_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [bls_pkg::X_W-1:0]     start_x;
  logic [bls_pkg::Y_W-1:0]     start_y;
  logic [bls_pkg::X_W-1:0]     end_x;
  logic [bls_pkg::Y_W-1:0]     end_y;
  logic [bls_pkg::COLOR_W-1:0] pen_color;

  modport source (
    output valid, start_x, start_y, end_x, end_y, pen_color,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y, pen_color,
    output ready
  );
endinterface

/* sv/bls_run_if.sv */
// ---------------------------------------------------------------------------
// bls_run_if: pixel run channel
// Valid/ready channel carrying one run of a rasterized line.
// ---------------------------------------------------------------------------
interface bls_run_if;
  logic                        valid;
  logic                        ready;
  logic [bls_pkg::X_W-1:0]     run_x;
  logic [bls_pkg::Y_W-1:0]     run_y;
  logic [bls_pkg::LEN_W-1:0]   run_length;
  logic                        run_vertical;
  logic [bls_pkg::COLOR_W-1:0] run_color;
  logic                        last_run;

  modport source (
    output valid, run_x, run_y, run_length, run_vertical, run_color, last_run,
    input  ready
  );

  modport sink (
    input  valid, run_x, run_y, run_length, run_vertical, run_color, last_run,
    output ready
  );
endinterface

/* sv/bls_front.sv */
// ---------------------------------------------------------------------------
// bls_front: command front end
// Clamps the endpoints, picks the major axis, orders the endpoints and
// derives the deltas and minor step direction for the walker.
// ---------------------------------------------------------------------------
module bls_front (
  bls_cmd_if.sink              cmd,
  output logic                 desc_valid,
  input  logic                 desc_ready,
  output bls_pkg::line_desc_t  desc
);

  logic [bls_pkg::X_W-1:0]     x0, x1;
  logic [bls_pkg::Y_W-1:0]     y0, y1;
  logic [bls_pkg::COORD_W-1:0] cx0, cx1, cy0, cy1;
  logic [bls_pkg::COORD_W-1:0] adx, ady;
  logic [bls_pkg::COORD_W-1:0] a0, a1, b0, b1;
  logic [bls_pkg::COORD_W-1:0] ma0, ma1, mb0, mb1;
  logic                        steep;

  // Transfer goes straight into the queue
  assign desc_valid = cmd.valid;
  assign cmd.ready  = desc_ready;

  // Clamp to screen and bring to a common coordinate width
  always_comb begin
    x0  = bls_pkg::sat_col(cmd.start_x);
    y0  = bls_pkg::sat_row(cmd.start_y);
    x1  = bls_pkg::sat_col(cmd.end_x);
    y1  = bls_pkg::sat_row(cmd.end_y);
    cx0 = bls_pkg::COORD_W'(x0);
    cx1 = bls_pkg::COORD_W'(x1);
    cy0 = bls_pkg::COORD_W'(y0);
    cy1 = bls_pkg::COORD_W'(y1);
  end

  // Absolute deltas; a tie is not steep
  assign adx   = (cx1 > cx0) ? (cx1 - cx0) : (cx0 - cx1);
  assign ady   = (cy1 > cy0) ? (cy1 - cy0) : (cy0 - cy1);
  assign steep = (ady > adx);

  // Axis swap for steep lines
  always_comb begin
    if (steep) begin
      a0 = cy0; b0 = cx0; a1 = cy1; b1 = cx1;
    end else begin
      a0 = cx0; b0 = cy0; a1 = cx1; b1 = cy1;
    end
  end

  // Endpoint order so the major coordinate increases
  always_comb begin
    if (a0 > a1) begin
      ma0 = a1; mb0 = b1; ma1 = a0; mb1 = b0;
    end else begin
      ma0 = a0; mb0 = b0; ma1 = a1; mb1 = b1;
    end
  end

  // Descriptor
  always_comb begin
    desc.major_start     = ma0;
    desc.major_end       = ma1;
    desc.minor_start     = mb0;
    desc.major_delta     = ma1 - ma0;
    desc.minor_delta     = (mb1 > mb0) ? (mb1 - mb0) : (mb0 - mb1);
    desc.minor_step_down = !(mb0 < mb1);
    desc.steep           = steep;
    desc.color           = cmd.pen_color;
  end

endmodule

/* sv/bls_queue.sv */
// ---------------------------------------------------------------------------
// bls_queue: line descriptor queue
// Short FIFO that lets the front end take a new command while the walker
// is still busy with an earlier line.
// ---------------------------------------------------------------------------
module bls_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bls_pkg::line_desc_t in_desc,
  output logic                out_valid,
  input  logic                out_ready,
  output bls_pkg::line_desc_t out_desc
);

  bls_pkg::line_desc_t              slots [bls_pkg::QUEUE_DEPTH];
  logic [bls_pkg::QPTR_W-1:0]       wr_ptr;
  logic [bls_pkg::QPTR_W-1:0]       rd_ptr;
  logic [bls_pkg::QCNT_W-1:0]       count;
  logic                             push;
  logic                             pop;

  assign in_ready  = (count != bls_pkg::QCNT_W'(bls_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_desc  = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_desc;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == bls_pkg::QPTR_W'(bls_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + bls_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == bls_pkg::QPTR_W'(bls_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + bls_pkg::QPTR_W'(1);
      end
      if (push && !pop) count <= count + bls_pkg::QCNT_W'(1);
      else if (pop && !push) count <= count - bls_pkg::QCNT_W'(1);
    end
  end

endmodule

/* sv/bls_walk.sv */
// ---------------------------------------------------------------------------
// bls_walk: span walker
// Steps one pixel per cycle along the major axis, while the output register can take a run, with the Bresenham error
// term and emits one run per minor coordinate into an output register.
// ---------------------------------------------------------------------------
module bls_walk (
  input  logic                clk,
  input  logic                rst,
  input  logic                desc_valid,
  output logic                desc_ready,
  input  bls_pkg::line_desc_t desc,
  bls_run_if.source           run
);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t                              state;
  bls_pkg::line_desc_t                 cur;
  logic [bls_pkg::COORD_W-1:0]         maj;
  logic [bls_pkg::COORD_W-1:0]         min;
  logic [bls_pkg::COORD_W-1:0]         run_start;
  logic [bls_pkg::LEN_W-1:0]           run_len;
  logic signed [bls_pkg::ERR_W-1:0]    err;

  logic                                out_valid;
  logic [bls_pkg::X_W-1:0]             out_x;
  logic [bls_pkg::Y_W-1:0]             out_y;
  logic [bls_pkg::LEN_W-1:0]           out_len;
  logic                                out_vertical;
  logic [bls_pkg::COLOR_W-1:0]         out_color;
  logic                                out_last;

  logic                                advance;
  logic                                at_end;
  logic                                stepped;
  logic                                emit;
  logic [bls_pkg::LEN_W-1:0]           run_len_inc;
  logic signed [bls_pkg::ERR_W-1:0]    err_sub;
  logic signed [bls_pkg::ERR_W-1:0]    err_next;
  logic [bls_pkg::COORD_W-1:0]         emit_x_src;
  logic [bls_pkg::COORD_W-1:0]         emit_y_src;

  // Take a new line only when idle; walk while the output slot can take a run
  assign desc_ready = (state == ST_IDLE);
  assign advance    = (state == ST_WALK) && (!out_valid || run.ready);

  // Error update and run boundary detection
  always_comb begin
    run_len_inc = run_len + bls_pkg::LEN_W'(1);
    err_sub     = err - $signed({1'b0, cur.minor_delta});
    stepped     = err_sub[bls_pkg::ERR_W-1];
    err_next    = stepped ? (err_sub + $signed({1'b0, cur.major_delta})) : err_sub;
    at_end      = (maj >= cur.major_end);
    emit        = advance && (at_end || stepped);
    emit_x_src  = cur.steep ? min : run_start;
    emit_y_src  = cur.steep ? run_start : min;
  end

  // Walk state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Output slot: load on emit, drop on transfer
      if (emit) begin
        out_valid <= 1'b1;
      end else if (run.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (desc_valid) begin
            cur       <= desc;
            maj       <= desc.major_start;
            min       <= desc.minor_start;
            run_start <= desc.major_start;
            run_len   <= '0;
            err       <= $signed({2'b00, desc.major_delta[bls_pkg::COORD_W-1:1]});
            state     <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (advance) begin
            err <= err_next;
            maj <= maj + bls_pkg::COORD_W'(1);
            if (at_end) begin
              state <= ST_IDLE;
            end else if (stepped) begin
              min       <= cur.minor_step_down ? (min - bls_pkg::COORD_W'(1))
                                               : (min + bls_pkg::COORD_W'(1));
              run_start <= maj + bls_pkg::COORD_W'(1);
              run_len   <= '0;
            end else begin
              run_len <= run_len_inc;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Run payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_x        <= bls_pkg::X_W'(emit_x_src);
      out_y        <= emit_y_src[bls_pkg::Y_W-1:0];
      out_len      <= run_len_inc;
      out_vertical <= cur.steep;
      out_color    <= cur.color;
      out_last     <= at_end;
    end
  end

  assign run.valid        = out_valid;
  assign run.run_x        = out_x;
  assign run.run_y        = out_y;
  assign run.run_length   = out_len;
  assign run.run_vertical = out_vertical;
  assign run.run_color    = out_color;
  assign run.last_run     = out_last;

  // A run never has zero pixels
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_len != '0))
    else $error("run with zero length");

  // The walk never passes the far endpoint
  a_maj_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (maj <= cur.major_end))
    else $error("major position beyond line end");

  // Error term stays non-negative between pixels
  a_err_nonneg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !err[bls_pkg::ERR_W-1])
    else $error("error term negative");

  // The final run ends the walk and is marked last
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (advance && at_end) |=> ((state == ST_IDLE) && out_valid && out_last))
    else $error("last run did not end the line");

  // No run is emitted without a line in progress
  a_emit_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_WALK))
    else $error("run emitted while idle");

endmodule

/* sv/bresenham_line_span_generator.sv */
// Timing: the walker loads a line in its idle state, then steps one pixel per
//   cycle along the major axis while the output slot can take a run; each run
//   is registered in the output slot when its last pixel is stepped. The walker
//   takes a new line only once it is back in its idle state.
// A two-entry descriptor queue takes new commands while a line is walked.
// Reset (rst, synchronous, active high) empties the queue and output slot.
// ---------------------------------------------------------------------------
// bresenham_line_span_generator: line span generator top level
// Rasterizes one line command with integer Bresenham and delivers the
// pixels as horizontal or vertical runs, one run per transfer.
// ---------------------------------------------------------------------------
module bresenham_line_span_generator (
  input  logic      clk,
  input  logic      rst,
  bls_cmd_if.sink   cmd,
  bls_run_if.source run
);

  logic                q_in_valid;
  logic                q_in_ready;
  bls_pkg::line_desc_t q_in_desc;
  logic                q_out_valid;
  logic                q_out_ready;
  bls_pkg::line_desc_t q_out_desc;

  // Command classification
  bls_front u_front (
    .cmd        (cmd),
    .desc_valid (q_in_valid),
    .desc_ready (q_in_ready),
    .desc       (q_in_desc)
  );

  // Descriptor queue
  bls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_desc   (q_in_desc),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_desc  (q_out_desc)
  );

  // Span walker
  bls_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (q_out_valid),
    .desc_ready (q_out_ready),
    .desc       (q_out_desc),
    .run        (run)
  );

endmodule
